// ===== rtl/point_dedup_index_table_macros.svh =====
// assertion macros for the point table checker
`ifndef POINT_DEDUP_INDEX_TABLE_MACROS_SVH
`define POINT_DEDUP_INDEX_TABLE_MACROS_SVH

// generic clocked assertion with reset qualification
`define PDIT_ASSERT_CLKRST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// assertion on the default clock and reset of the block
`define PDIT_ASSERT(lbl, prop, msg) \
  `PDIT_ASSERT_CLKRST(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== rtl/pdit_pkg.sv =====
// shared types and constants of the deduplicating point index table
package pdit_pkg;

  localparam int unsigned NumTables         = 3;
  localparam int unsigned DefPointsPerTable = 256;
  localparam int unsigned CoordW            = 32;
  localparam int unsigned KeyW              = 2 * CoordW;
  localparam int unsigned IndexW            = 8;
  localparam int unsigned SelW              = 2;
  localparam int unsigned KindW             = 2;

  typedef enum logic [KindW-1:0] {
    KIND_START  = 2'd0,
    KIND_ADD    = 2'd1,
    KIND_FINISH = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    STATUS_OK          = 3'd0,
    STATUS_DONE        = 3'd1,
    STATUS_BUSY        = 3'd2,
    STATUS_NOT_STARTED = 3'd3,
    STATUS_FULL        = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    PHASE_IDLE = 2'd0,
    PHASE_INIT = 2'd1,
    PHASE_DONE = 2'd2
  } phase_e;

  typedef enum logic {
    CTRL_IDLE = 1'b0,
    CTRL_SCAN = 1'b1
  } ctrl_state_e;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } store_ctl_t;

  typedef struct packed {
    status_e             status;
    logic [IndexW-1:0]   index;
    logic                fresh;
  } result_t;

endpackage

// ===== rtl/pdit_store.sv =====
// point memory with registered read port and key compare
module pdit_store
  import pdit_pkg::*;
#(
  parameter int unsigned PointsPerTable = DefPointsPerTable,
  localparam int unsigned Depth = NumTables * PointsPerTable,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  store_ctl_t       ctl_i,
  input  logic [AddrW-1:0] rd_addr_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [KeyW-1:0]  key_i,
  output logic             hit_o
);

  logic [KeyW-1:0] mem [Depth];
  logic [KeyW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[wr_addr_i] <= key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rdata_q <= mem[rd_addr_i];
    end
  end

  // x in the low half, y in the high half, exact match on both
  assign hit_o = (rdata_q == key_i);

endmodule

// ===== rtl/pdit_ctrl.sv =====
// phase tracking, fill counts and sequential table scan
module pdit_ctrl
  import pdit_pkg::*;
#(
  parameter int unsigned PointsPerTable = DefPointsPerTable,
  localparam int unsigned AddrW = $clog2(NumTables * PointsPerTable),
  localparam int unsigned CntW  = $clog2(PointsPerTable + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [KindW-1:0] kind_i,
  input  logic [SelW-1:0]  sel_i,
  input  logic [KeyW-1:0]  key_i,
  output logic             res_valid_o,
  output result_t          res_o,
  input  logic             res_take_i,
  output store_ctl_t       store_ctl_o,
  output logic [AddrW-1:0] rd_addr_o,
  output logic [AddrW-1:0] wr_addr_o,
  output logic [KeyW-1:0]  key_o,
  input  logic             hit_i
);

  localparam logic [SelW-1:0] SelLimit = SelW'(NumTables);
  localparam logic [CntW-1:0] CntFull  = CntW'(PointsPerTable);

  ctrl_state_e      state_q, state_d;
  phase_e           phase_q, phase_d;
  logic [CntW-1:0]  fill_q [NumTables];
  logic [CntW-1:0]  fill_d [NumTables];
  logic [KeyW-1:0]  key_q, key_d;
  logic [SelW-1:0]  sel_q, sel_d;
  logic [CntW-1:0]  used_q, used_d;
  logic [CntW-1:0]  rd_idx_q, rd_idx_d;
  logic             pend_q, pend_d;
  logic [CntW-1:0]  pend_idx_q, pend_idx_d;
  result_t          res_q, res_d;
  logic             res_valid_q, res_valid_d;

  logic             accept;
  logic             add_go;
  logic             issue;
  logic             hit_now;
  logic             miss_now;
  logic [AddrW-1:0] base_addr;

  assign in_ready_o = (state_q == CTRL_IDLE) && !res_valid_q;
  assign accept     = in_valid_i && in_ready_o;
  assign add_go     = accept && (kind_e'(kind_i) == KIND_ADD) &&
                      (phase_q == PHASE_INIT) && (sel_i < SelLimit);

  // one read issued per cycle, compared against the key in the cycle after its issue
  assign issue    = (state_q == CTRL_SCAN) && (rd_idx_q < used_q);
  assign hit_now  = (state_q == CTRL_SCAN) && pend_q && hit_i;
  assign miss_now = (state_q == CTRL_SCAN) && !issue && !hit_now;

  always_comb begin
    case (sel_q)
      2'd1:    base_addr = AddrW'(PointsPerTable);
      2'd2:    base_addr = AddrW'(2 * PointsPerTable);
      default: base_addr = '0;
    endcase
  end

  assign rd_addr_o   = base_addr + AddrW'(rd_idx_q);
  assign wr_addr_o   = base_addr + AddrW'(used_q);
  assign key_o       = key_q;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      CTRL_IDLE: begin
        if (add_go) begin
          state_d = CTRL_SCAN;
        end
      end
      CTRL_SCAN: begin
        if (hit_now || miss_now) begin
          state_d = CTRL_IDLE;
        end
      end
      default: state_d = CTRL_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    result_t res_new;
    logic    res_set;
    res_new      = '0;
    res_new.status = STATUS_OK;
    res_set      = 1'b0;
    phase_d      = phase_q;
    fill_d       = fill_q;
    key_d        = key_q;
    sel_d        = sel_q;
    used_d       = used_q;
    rd_idx_d     = rd_idx_q;
    pend_d       = 1'b0;
    pend_idx_d   = rd_idx_q;
    res_d        = res_q;
    res_valid_d  = res_valid_q && !res_take_i;
    store_ctl_o  = '0;

    if (accept) begin
      res_set = 1'b1;
      case (kind_e'(kind_i))
        KIND_START: begin
          if (phase_q == PHASE_DONE) begin
            res_new.status = STATUS_DONE;
          end else if (phase_q == PHASE_INIT) begin
            res_new.status = STATUS_BUSY;
          end else begin
            for (int t = 0; t < NumTables; t++) fill_d[t] = '0;
            phase_d = PHASE_INIT;
          end
        end
        KIND_CLEAR: begin
          for (int t = 0; t < NumTables; t++) fill_d[t] = '0;
          phase_d = PHASE_IDLE;
        end
        KIND_FINISH: begin
          if (phase_q == PHASE_DONE) begin
            res_new.status = STATUS_DONE;
          end else if (phase_q == PHASE_INIT) begin
            phase_d = PHASE_DONE;
          end else begin
            res_new.status = STATUS_NOT_STARTED;
          end
        end
        KIND_ADD: begin
          if (phase_q == PHASE_DONE) begin
            res_new.status = STATUS_DONE;
          end else if (phase_q != PHASE_INIT) begin
            res_new.status = STATUS_NOT_STARTED;
          end else if (sel_i >= SelLimit) begin
            // no such table
            res_new.status = STATUS_FULL;
          end else begin
            res_set  = 1'b0;
            key_d    = key_i;
            sel_d    = sel_i;
            used_d   = fill_q[sel_i];
            rd_idx_d = '0;
          end
        end
        default: res_new.status = STATUS_OK;
      endcase
    end

    if (state_q == CTRL_SCAN) begin
      store_ctl_o.rd_en = issue;
      rd_idx_d          = rd_idx_q + CntW'(issue);
      pend_d            = issue;
      if (hit_now) begin
        res_set       = 1'b1;
        res_new.index = IndexW'(pend_idx_q);
      end else if (miss_now) begin
        res_set = 1'b1;
        if (used_q == CntFull) begin
          res_new.status = STATUS_FULL;
        end else begin
          store_ctl_o.wr_en = 1'b1;
          fill_d[sel_q]     = used_q + CntW'(1);
          res_new.index     = IndexW'(used_q);
          res_new.fresh     = 1'b1;
        end
      end
    end

    if (res_set) begin
      res_d       = res_new;
      res_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CTRL_IDLE;
      phase_q     <= PHASE_IDLE;
      fill_q      <= '{default: '0};
      rd_idx_q    <= '0;
      pend_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      fill_q      <= fill_d;
      rd_idx_q    <= rd_idx_d;
      pend_q      <= pend_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q      <= key_d;
    sel_q      <= sel_d;
    used_q     <= used_d;
    pend_idx_q <= pend_idx_d;
    res_q      <= res_d;
  end

endmodule

// ===== rtl/point_dedup_index_table.sv =====
// Deduplicating point index table, three tables of 2D points.
// Requests enter on the s_axis channel: tuser carries kind and table select,
// tdata carries the x and y coordinates. Each request gives exactly one
// response on m_axis: tdata holds the point index, tuser the status and the
// newly-added flag. Start, finish and clear are answered through the
// controller's result register and then the output register. An add scans
// the selected table in the point memory one entry per cycle through its
// single read port, and answers once its compare hits or, for a new point,
// once every filled entry has been read. One request is in work at a time;
// a finished response waits in the output register and the next request is
// taken meanwhile, but a further response is held in the controller until
// the receiver drains the output. Reset returns to the idle phase with all
// tables empty and takes effect at once; the point memory needs no clearing
// since only filled entries are ever read.
module point_dedup_index_table
  import pdit_pkg::*;
#(
  parameter int unsigned PointsPerTable = DefPointsPerTable
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // x_coord[31:0], y_coord[63:32]
  input  logic [3:0]  s_axis_tuser_i,   // kind[1:0], table_sel[3:2]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // point_index[7:0]
  output logic [3:0]  m_axis_tuser_o    // status[2:0], newly_added[3]
);

  localparam int unsigned AddrW = $clog2(NumTables * PointsPerTable);

  store_ctl_t       store_ctl;
  logic [AddrW-1:0] rd_addr;
  logic [AddrW-1:0] wr_addr;
  logic [KeyW-1:0]  key;
  logic             hit;
  logic             res_valid;
  result_t          res;
  logic             res_take;
  logic             out_valid_q, out_valid_d;
  result_t          out_q;

  pdit_ctrl #(
    .PointsPerTable(PointsPerTable)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .kind_i      (s_axis_tuser_i[KindW-1:0]),
    .sel_i       (s_axis_tuser_i[KindW+SelW-1:KindW]),
    .key_i       (s_axis_tdata_i),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_take_i  (res_take),
    .store_ctl_o (store_ctl),
    .rd_addr_o   (rd_addr),
    .wr_addr_o   (wr_addr),
    .key_o       (key),
    .hit_i       (hit)
  );

  pdit_store #(
    .PointsPerTable(PointsPerTable)
  ) u_store (
    .clk_i     (clk_i),
    .ctl_i     (store_ctl),
    .rd_addr_i (rd_addr),
    .wr_addr_i (wr_addr),
    .key_i     (key),
    .hit_o     (hit)
  );

  // output register, refilled in the cycle the receiver takes it
  assign res_take    = res_valid && (!out_valid_q || m_axis_tready_i);
  assign out_valid_d = res_take || (out_valid_q && !m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q.index;
  assign m_axis_tuser_o  = {out_q.fresh, out_q.status};

endmodule

// ===== rtl/pdit_checker.sv =====
// port-level checks for the point table, bound to the top level
`include "point_dedup_index_table_macros.svh"

module pdit_checker
  import pdit_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_tvalid_i,
  input logic        s_tready_i,
  input logic        m_tvalid_i,
  input logic        m_tready_i,
  input logic [7:0]  m_tdata_i,
  input logic [3:0]  m_tuser_i
);

  `PDIT_ASSERT(a_out_hold, m_tvalid_i && !m_tready_i |=> m_tvalid_i && $stable(m_tdata_i) && $stable(m_tuser_i), "response changed while stalled")
  `PDIT_ASSERT(a_one_in_work, s_tvalid_i && s_tready_i |=> !s_tready_i, "request taken while one is in work")
  `PDIT_ASSERT(a_fresh_ok, m_tvalid_i && m_tuser_i[3] |-> m_tuser_i[2:0] == STATUS_OK, "new entry flagged on a failed request")
  `PDIT_ASSERT(a_fail_zero, m_tvalid_i && m_tuser_i[2:0] != STATUS_OK |-> m_tdata_i == 8'd0 && !m_tuser_i[3], "failed request carries an index")

endmodule

bind point_dedup_index_table pdit_checker u_pdit_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_axis_tvalid_i),
  .s_tready_i (s_axis_tready_o),
  .m_tvalid_i (m_axis_tvalid_o),
  .m_tready_i (m_axis_tready_i),
  .m_tdata_i  (m_axis_tdata_o),
  .m_tuser_i  (m_axis_tuser_o)
);

// ===== sim/tb_point_dedup_index_table.sv =====
// testbench for the deduplicating point index table: directed table, then random sessions
`timescale 1ns / 1ps

module tb_point_dedup_index_table;
  import pdit_pkg::*;

  localparam int unsigned TablePoints   = DefPointsPerTable;
  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned DrainCycles   = 300;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned RandomItems   = 1500;
  localparam int unsigned DirRows       = 26;

  typedef struct packed {
    kind_e       kind;
    logic [1:0]  sel;
    logic [31:0] x;
    logic [31:0] y;
    logic        typed;
    result_t     want;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic [3:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic [3:0]  m_axis_tuser;

  // predictor state
  logic [63:0]  tbl_key [NumTables][TablePoints];
  int unsigned  tbl_fill [NumTables];
  phase_e       cur_phase;

  result_t      pending_resp [$];
  logic [63:0]  seen_keys [$];
  dir_row_t     dir_rows [DirRows];
  int           mismatches = 0;
  int           items_sent = 0;
  int           resp_seen = 0;
  int           src_burst = 0;
  int           sink_burst = 0;
  int           fills_done = 0;
  bit           held_off = 1'b0;
  bit           paused_mid = 1'b0;
  int unsigned  idle_cycles = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  point_dedup_index_table dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser)
  );

  function automatic void clear_tables();
    int t;
    for (t = 0; t < NumTables; t++) tbl_fill[t] = 0;
  endfunction

  function automatic result_t predict_response(kind_e k, logic [1:0] sel, logic [63:0] key);
    result_t     r;
    int unsigned used;
    int          i;
    bit          found;
    r.status = STATUS_OK;
    r.index  = '0;
    r.fresh  = 1'b0;
    found    = 1'b0;
    case (k)
      KIND_START: begin
        if (cur_phase == PHASE_DONE) r.status = STATUS_DONE;
        else if (cur_phase == PHASE_INIT) r.status = STATUS_BUSY;
        else begin
          clear_tables();
          cur_phase = PHASE_INIT;
        end
      end
      KIND_CLEAR: begin
        clear_tables();
        cur_phase = PHASE_IDLE;
      end
      default: begin
        if (cur_phase == PHASE_DONE) r.status = STATUS_DONE;
        else if (cur_phase != PHASE_INIT) r.status = STATUS_NOT_STARTED;
        else if (k == KIND_FINISH) cur_phase = PHASE_DONE;
        else if (sel >= NumTables) r.status = STATUS_FULL;
        else begin
          used = tbl_fill[sel];
          for (i = 0; i < used; i++) begin
            if (!found && tbl_key[sel][i] == key) begin
              found   = 1'b1;
              r.index = 8'(i);
            end
          end
          if (!found) begin
            if (used >= TablePoints) r.status = STATUS_FULL;
            else begin
              tbl_key[sel][used] = key;
              tbl_fill[sel]      = used + 1;
              r.index            = 8'(used);
              r.fresh            = 1'b1;
            end
          end
        end
      end
    endcase
    return r;
  endfunction

  // wait for one side: bursts without gaps now and then, else a uniformly drawn wait
  function automatic int draw_wait(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) burst = $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  task automatic send_request(kind_e k, logic [1:0] sel, logic [31:0] x, logic [31:0] y,
                              logic typed, result_t want);
    int      gap;
    result_t got;
    gap = draw_wait(src_burst);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {y, x};
    s_axis_tuser  <= {sel, k};
    do @(posedge clk_i); while (!s_axis_tready);
    got = predict_response(k, sel, {y, x});
    pending_resp.insert(pending_resp.size(), typed ? want : got);
    items_sent++;
  endtask

  task automatic send_plain(kind_e k);
    send_request(k, 2'($urandom_range(0, 3)), $urandom, $urandom, 1'b0, '0);
  endtask

  // sender holds off until every response is back
  task automatic drain_responses();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_resp.size() != 0);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 15))
      0: return 32'h0000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h8000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [1:0] pick_table();
    if ($urandom_range(0, 29) == 0) return 2'd3;
    return 2'($urandom_range(0, 2));
  endfunction

  task automatic add_point(logic [1:0] sel);
    logic [63:0] key;
    int          pick;
    pick = $urandom_range(0, 9);
    if (seen_keys.size() != 0 && pick < 4) begin
      key = seen_keys[$urandom_range(0, seen_keys.size() - 1)];
    end else if (seen_keys.size() != 0 && pick == 4) begin
      // near miss: one bit off a stored point
      key = seen_keys[$urandom_range(0, seen_keys.size() - 1)];
      key[$urandom_range(0, 63)] ^= 1'b1;
      seen_keys.insert(seen_keys.size(), key);
    end else begin
      key = {rand_coord(), rand_coord()};
      seen_keys.insert(seen_keys.size(), key);
    end
    send_request(KIND_ADD, sel, key[31:0], key[63:32], 1'b0, '0);
  endtask

  // fill one table to the top, then hit it with known and unknown points, then add one point to the next table
  task automatic fill_table();
    logic [1:0]  sel;
    logic [63:0] key;
    int          i;
    sel = 2'($urandom_range(0, 2));
    for (i = 0; i < TablePoints; i++) begin
      key = {$urandom, $urandom};
      seen_keys.insert(seen_keys.size(), key);
      send_request(KIND_ADD, sel, key[31:0], key[63:32], 1'b0, '0);
    end
    for (i = 0; i < 16; i++) begin
      if (i % 2) key = seen_keys[$urandom_range(0, TablePoints - 1)];
      else key = {rand_coord(), rand_coord()};
      send_request(KIND_ADD, sel, key[31:0], key[63:32], 1'b0, '0);
    end
    add_point(2'((sel + 1) % NumTables));
    fills_done++;
  endtask

  task automatic run_session();
    int n_adds;
    int i;
    seen_keys.delete();
    send_plain(KIND_START);
    if ((fills_done == 0 && items_sent > 300) || (fills_done == 1 && items_sent > 900)) begin
      fill_table();
    end else begin
      n_adds = $urandom_range(1, 40);
      for (i = 0; i < n_adds; i++) begin
        case ($urandom_range(0, 39))
          0: send_plain(KIND_START);
          1: send_plain(KIND_FINISH);
          default: add_point(pick_table());
        endcase
      end
    end
    send_plain(KIND_FINISH);
    repeat ($urandom_range(0, 3)) send_plain(kind_e'($urandom_range(0, 2)));
    if ($urandom_range(0, 7) != 0) send_plain(KIND_CLEAR);
  endtask

  task automatic check_response();
    result_t want;
    resp_seen++;
    if (pending_resp.size() == 0) begin
      $error("response with none pending: status %0d index %0d new %0d",
             m_axis_tuser[2:0], m_axis_tdata, m_axis_tuser[3]);
      mismatches++;
      return;
    end
    want = pending_resp.pop_front();
    if (m_axis_tuser[2:0] !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, m_axis_tuser[2:0]);
      mismatches++;
    end
    if (m_axis_tdata !== want.index) begin
      $error("point_index: expected %0d, got %0d", want.index, m_axis_tdata);
      mismatches++;
    end
    if (m_axis_tuser[3] !== want.fresh) begin
      $error("newly_added: expected %0d, got %0d", want.fresh, m_axis_tuser[3]);
      mismatches++;
    end
  endtask

  // response side
  initial begin
    int stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = draw_wait(sink_burst);
      if (resp_seen >= 200 && !held_off) begin
        stall    = HoldOffCycles;
        held_off = 1'b1;
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      check_response();
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WatchdogLimit) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // request side and end of run
  initial begin
    int r;
    dir_rows[0]  = '{KIND_ADD,    2'd0, 32'h0,         32'h0,         1'b1,
                     '{STATUS_NOT_STARTED, 8'd0, 1'b0}};
    dir_rows[1]  = '{KIND_FINISH, 2'd0, 32'h0,         32'h0,         1'b1,
                     '{STATUS_NOT_STARTED, 8'd0, 1'b0}};
    dir_rows[2]  = '{KIND_START,  2'd3, 32'hffff_ffff, 32'hffff_ffff, 1'b1,
                     '{STATUS_OK, 8'd0, 1'b0}};
    dir_rows[3]  = '{KIND_START,  2'd0, 32'h0,         32'h0,         1'b1,
                     '{STATUS_BUSY, 8'd0, 1'b0}};
    dir_rows[4]  = '{KIND_ADD,    2'd0, 32'h7fff_ffff, 32'h8000_0000, 1'b1,
                     '{STATUS_OK, 8'd0, 1'b1}};
    dir_rows[5]  = '{KIND_ADD,    2'd0, 32'h7fff_ffff, 32'h8000_0000, 1'b1,
                     '{STATUS_OK, 8'd0, 1'b0}};
    dir_rows[6]  = '{KIND_ADD,    2'd0, 32'h8000_0000, 32'h7fff_ffff, 1'b1,
                     '{STATUS_OK, 8'd1, 1'b1}};
    dir_rows[7]  = '{KIND_ADD,    2'd0, 32'h0,         32'h0,         1'b1,
                     '{STATUS_OK, 8'd2, 1'b1}};
    dir_rows[8]  = '{KIND_ADD,    2'd0, 32'hffff_ffff, 32'hffff_ffff, 1'b1,
                     '{STATUS_OK, 8'd3, 1'b1}};
    dir_rows[9]  = '{KIND_ADD,    2'd1, 32'h7fff_ffff, 32'h8000_0000, 1'b1,
                     '{STATUS_OK, 8'd0, 1'b1}};
    dir_rows[10] = '{KIND_ADD,    2'd2, 32'h0,         32'h0,         1'b1,
                     '{STATUS_OK, 8'd0, 1'b1}};
    // no fourth table
    dir_rows[11] = '{KIND_ADD,    2'd3, 32'h1,         32'h1,         1'b1,
                     '{STATUS_FULL, 8'd0, 1'b0}};
    dir_rows[12] = '{KIND_ADD,    2'd0, 32'h0,         32'h1,         1'b0, '0};
    dir_rows[13] = '{KIND_ADD,    2'd0, 32'h1,         32'h0,         1'b0, '0};
    dir_rows[14] = '{KIND_ADD,    2'd0, 32'h0,         32'h0,         1'b1,
                     '{STATUS_OK, 8'd2, 1'b0}};
    dir_rows[15] = '{KIND_ADD,    2'd0, 32'h8000_0000, 32'h7fff_ffff, 1'b0, '0};
    dir_rows[16] = '{KIND_FINISH, 2'd0, 32'h0,         32'h0,         1'b1,
                     '{STATUS_OK, 8'd0, 1'b0}};
    dir_rows[17] = '{KIND_ADD,    2'd0, 32'h0,         32'h0,         1'b1,
                     '{STATUS_DONE, 8'd0, 1'b0}};
    dir_rows[18] = '{KIND_FINISH, 2'd0, 32'h0,         32'h0,         1'b1,
                     '{STATUS_DONE, 8'd0, 1'b0}};
    dir_rows[19] = '{KIND_START,  2'd0, 32'h0,         32'h0,         1'b1,
                     '{STATUS_DONE, 8'd0, 1'b0}};
    dir_rows[20] = '{KIND_CLEAR,  2'd0, 32'h0,         32'h0,         1'b1,
                     '{STATUS_OK, 8'd0, 1'b0}};
    dir_rows[21] = '{KIND_START,  2'd0, 32'h0,         32'h0,         1'b1,
                     '{STATUS_OK, 8'd0, 1'b0}};
    // tables start empty again
    dir_rows[22] = '{KIND_ADD,    2'd0, 32'h0,         32'h0,         1'b1,
                     '{STATUS_OK, 8'd0, 1'b1}};
    dir_rows[23] = '{KIND_CLEAR,  2'd1, 32'h0,         32'h0,         1'b1,
                     '{STATUS_OK, 8'd0, 1'b0}};
    dir_rows[24] = '{KIND_CLEAR,  2'd0, 32'h0,         32'h0,         1'b1,
                     '{STATUS_OK, 8'd0, 1'b0}};
    dir_rows[25] = '{KIND_ADD,    2'd3, 32'h0,         32'h0,         1'b1,
                     '{STATUS_NOT_STARTED, 8'd0, 1'b0}};

    clear_tables();
    cur_phase = PHASE_IDLE;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (r = 0; r < DirRows; r++) begin
      send_request(dir_rows[r].kind, dir_rows[r].sel, dir_rows[r].x, dir_rows[r].y,
                   dir_rows[r].typed, dir_rows[r].want);
    end
    drain_responses();

    while (items_sent < RandomItems) begin
      if (!paused_mid && items_sent > 700) begin
        drain_responses();
        paused_mid = 1'b1;
      end
      if ($urandom_range(0, 11) == 0) begin
        repeat ($urandom_range(1, 6)) send_plain(kind_e'($urandom_range(0, 3)));
      end else begin
        run_session();
      end
    end
    drain_responses();
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/pdit_pkg.sv
rtl/pdit_store.sv
rtl/pdit_ctrl.sv
rtl/point_dedup_index_table.sv
rtl/pdit_checker.sv
sim/tb_point_dedup_index_table.sv
